/* hdl/slsc_pkg.sv */
`timescale 1ns / 1ps

package slsc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_MUL,
        S_ADD,
        S_STORE,
        S_OUT
    } t_state;

    // the four multiply steps of one channel, in the order they run
    localparam logic [1:0] STEP_POS_FIX  = 2'd0;
    localparam logic [1:0] STEP_POS_CLIP = 2'd1;
    localparam logic [1:0] STEP_NEG_FIX  = 2'd2;
    localparam logic [1:0] STEP_NEG_CLIP = 2'd3;

    // register map (word index)
    localparam logic REG_SPACING = 1'b0;

    localparam int          SPACING_W     = 5;
    localparam logic [4:0]  SPACING_RESET = 5'd1;

    // blend and threshold constants, unsigned Q0.20
    localparam int K_A20 = 740107;
    localparam int K_S20 = 273589;
    localparam int K_B20 = 261275;
    localparam int K_H20 = 774987;
    localparam int K_T20 = 1001382;

    // rescale a Q0.20 constant to frac_bits, rounding half up when narrowing
    function automatic int slsc_scale(input int c20, input int frac_bits);
        int res;
        if (frac_bits >= 20) begin
            res = c20 << (frac_bits - 20);
        end else begin
            res = (c20 + (1 << (19 - frac_bits))) >> (20 - frac_bits);
        end
        return res;
    endfunction

endpackage

/* hdl/stereo_lookahead_soft_clipper.sv */
`timescale 1ns / 1ps

// Stereo soft clipper. Each transfer on the input channel carries one stereo
// pair in signed Q3.F (F = SAMPLE_BITS - 4); each channel is clamped to +-4.0,
// samples beyond +-0.9549925859 are replaced by a softened value built from
// the held sample, and the held sample of the previous transfer is reshaped
// when a clip flag is armed. The result for a pair is the held (previous,
// possibly reshaped) sample of each channel, so the latency is one pair for
// every spacing value. Ready stays low from an input transfer until that pair
// is through, so a new pair waits for the last one: the per-channel state (held
// sample and two clip flags) sits in a two-entry synchronous memory that is
// read, updated through four multiply and add steps on one shared multiplier,
// and written back, left channel then right, and then the output register is
// loaded. A finished result waits in the output register
// while the next pair is accepted and processed; if it has still not been
// taken when the next result is ready, the block holds before the load and
// input ready stays low for as long as that lasts. The spacing register
// (address 0, reset 1) is kept for software and reads back its low five bits
// as written; it does not change the output.
module stereo_lookahead_soft_clipper
    import slsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_right,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_left,
    output logic signed [SAMPLE_BITS-1:0] o_out_right,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SAMPLE_BITS - 4;
    localparam int PW = SB + F + 2;
    localparam int EW = SB + 2;

    localparam logic [F:0] K_A = (F+1)'(slsc_scale(K_A20, F));
    localparam logic [F:0] K_S = (F+1)'(slsc_scale(K_S20, F));
    localparam logic [F:0] K_B = (F+1)'(slsc_scale(K_B20, F));
    localparam logic [F:0] K_H = (F+1)'(slsc_scale(K_H20, F));
    localparam logic [F:0] K_T = (F+1)'(slsc_scale(K_T20, F));

    localparam logic signed [SB-1:0] C_A   = SB'(K_A);
    localparam logic signed [SB-1:0] C_B   = SB'(K_B);
    localparam logic signed [SB-1:0] T_POS = SB'(K_T);
    localparam logic signed [SB-1:0] T_NEG = -T_POS;
    localparam logic signed [SB-1:0] LIM_P = SB'(1) <<< (SB - 2);
    localparam logic signed [SB-1:0] LIM_N = -LIM_P;
    localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (F - 1);

    t_state r_state, n_state;

    logic                 r_ch;
    logic [1:0]           r_step;
    logic signed [SB-1:0] r_in_l, r_in_r;
    logic signed [SB-1:0] r_x, r_held;
    logic                 r_pos, r_neg, r_alt;
    logic signed [PW-1:0] r_prod;
    logic signed [SB-1:0] r_res_l;
    logic signed [SB-1:0] r_out_l, r_out_r;
    logic                 r_out_valid;
    logic [SPACING_W-1:0] r_spacing;
    logic [1:0]           r_vld;
    logic [EW-1:0]        r_mem [2];
    logic [EW-1:0]        r_rd_data;

    logic                 w_mem_we;
    logic                 w_out_load;
    logic                 w_cfg_we;
    logic signed [SB-1:0] w_src, w_xc;
    logic signed [SB-1:0] w_rd_held;
    logic                 w_rd_pos, w_rd_neg;
    logic signed [SB-1:0] w_mul_a;
    logic signed [F+1:0]  w_mul_k;
    logic                 w_alt;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_rnd_full;
    logic signed [SB-1:0] w_rnd;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_SPACING);
    assign prdata   = (paddr[2] == REG_SPACING) ? {{(32-SPACING_W){1'b0}}, r_spacing} : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_step == STEP_NEG_CLIP) ? S_STORE : S_MUL;
            S_STORE: n_state = r_ch ? S_OUT : S_READ;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_STORE: w_mem_we   = 1'b1;
            S_OUT:   w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // clamp of the current channel sample
    assign w_src = r_ch ? r_in_r : r_in_l;
    always_comb begin
        w_xc = w_src;
        if (w_src > LIM_P) w_xc = LIM_P;
        if (w_src < LIM_N) w_xc = LIM_N;
    end

    // state memory read data, unwritten entries read as zero
    assign w_rd_held = r_vld[r_ch] ? $signed(r_rd_data[EW-1:2]) : '0;
    assign w_rd_pos  = r_vld[r_ch] & r_rd_data[1];
    assign w_rd_neg  = r_vld[r_ch] & r_rd_data[0];

    // operand selection for the shared multiplier
    always_comb begin
        w_alt   = 1'b0;
        w_mul_a = r_held;
        w_mul_k = $signed({1'b0, K_S});
        case (r_step)
            STEP_POS_FIX: begin
                w_alt   = r_x < r_held;
                w_mul_a = w_alt ? r_x : r_held;
                w_mul_k = w_alt ? $signed({1'b0, K_S}) : $signed({1'b0, K_H});
            end
            STEP_NEG_FIX: begin
                w_alt   = r_x > r_held;
                w_mul_a = w_alt ? r_x : r_held;
                w_mul_k = w_alt ? $signed({1'b0, K_S}) : $signed({1'b0, K_H});
            end
            default: ;
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_k;
    // round to nearest, ties upward
    assign w_rnd_full = (r_prod + HALF) >>> F;
    assign w_rnd      = w_rnd_full[SB-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_step      <= STEP_POS_FIX;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_spacing   <= SPACING_RESET;
        end else begin
            r_state <= n_state;
            if (w_cfg_we) r_spacing <= pwdata[SPACING_W-1:0];
            if (r_state == S_LOAD) r_step <= STEP_POS_FIX;
            if (r_state == S_ADD) r_step <= r_step + 2'd1;
            if (w_mem_we) begin
                r_ch        <= ~r_ch;
                r_vld[r_ch] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // channel state memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_ch] <= {r_x, r_pos, r_neg};
        r_rd_data <= r_mem[r_ch];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in_l <= i_sample_left;
            r_in_r <= i_sample_right;
        end
        case (r_state)
            S_LOAD: begin
                r_x    <= w_xc;
                r_held <= w_rd_held;
                r_pos  <= w_rd_pos;
                r_neg  <= w_rd_neg;
            end
            S_MUL: begin
                r_prod <= w_prod;
                r_alt  <= w_alt;
            end
            S_ADD: begin
                case (r_step)
                    STEP_POS_FIX: begin
                        if (r_pos) r_held <= (r_alt ? C_A : C_B) + w_rnd;
                    end
                    STEP_POS_CLIP: begin
                        r_pos <= r_x > T_POS;
                        if (r_x > T_POS) r_x <= C_A + w_rnd;
                    end
                    STEP_NEG_FIX: begin
                        if (r_neg) r_held <= w_rnd - (r_alt ? C_A : C_B);
                    end
                    STEP_NEG_CLIP: begin
                        r_neg <= r_x < T_NEG;
                        if (r_x < T_NEG) r_x <= w_rnd - C_A;
                    end
                    default: ;
                endcase
            end
            S_STORE: begin
                if (!r_ch) r_res_l <= r_held;
                else       r_out_r <= r_held;
            end
            default: ;
        endcase
        if (w_out_load) r_out_l <= r_res_l;
    end

    // output register: right result is held apart until the load
    logic signed [SB-1:0] r_res_r_q;
    always_ff @(posedge i_clk) begin
        if (w_out_load) r_res_r_q <= r_out_r;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_res_r_q;

endmodule

/* dv/stereo_lookahead_soft_clipper_tb.sv */
`timescale 1ns / 1ps

module stereo_lookahead_soft_clipper_tb;
    import slsc_pkg::*;

    localparam int     SB        = 24;
    localparam longint LIM       = longint'(4) << 20;
    localparam longint K_A       = K_A20;
    localparam longint K_S       = K_S20;
    localparam longint K_B       = K_B20;
    localparam longint K_H       = K_H20;
    localparam longint K_T       = K_T20;
    localparam int     CYCLE_CAP = 400000;
    localparam int     PHASES    = 6;
    localparam int     PER_PHASE = 230;

    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
    } t_pair;

    // clipped pair tracking: per-channel shaping state and the results still due
    class clip_scoreboard;
        longint held [2];
        bit     pos  [2];
        bit     neg  [2];
        t_pair  due  [$];
        int     errors;

        function new();
            for (int c = 0; c < 2; c++) begin
                held[c] = 0;
                pos[c]  = 1'b0;
                neg[c]  = 1'b0;
            end
            errors = 0;
        endfunction

        // product with a Q0.20 blend, rounded half toward plus infinity
        function longint blend(longint v, longint k);
            return (v * k + (longint'(1) << 19)) >>> 20;
        endfunction

        function logic [SB-1:0] shape(int ch, logic signed [SB-1:0] smp);
            longint x;
            longint res;
            x = smp;
            if (x > LIM) x = LIM;
            if (x < -LIM) x = -LIM;
            // positive flag reshapes the held sample, then a new positive clip
            if (pos[ch]) begin
                if (x < held[ch]) held[ch] = K_A + blend(x, K_S);
                else held[ch] = K_B + blend(held[ch], K_H);
            end
            pos[ch] = 1'b0;
            if (x > K_T) begin
                pos[ch] = 1'b1;
                x = K_A + blend(held[ch], K_S);
            end
            // negative side, working on the possibly replaced sample
            if (neg[ch]) begin
                if (x > held[ch]) held[ch] = -K_A + blend(x, K_S);
                else held[ch] = -K_B + blend(held[ch], K_H);
            end
            neg[ch] = 1'b0;
            if (x < -K_T) begin
                neg[ch] = 1'b1;
                x = -K_A + blend(held[ch], K_S);
            end
            res = held[ch];
            // first tap of the delay line is always the newest processed sample
            held[ch] = x;
            return res[SB-1:0];
        endfunction

        function void note_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
            t_pair p;
            p.left  = shape(0, l);
            p.right = shape(1, r);
            due.push_back(p);
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_pair(logic [SB-1:0] l, logic [SB-1:0] r);
            t_pair want;
            if (due.size() == 0) begin
                report($sformatf("result %0d %0d with nothing due",
                                 $signed(l), $signed(r)));
                return;
            end
            want = due.pop_front();
            if (l !== want.left)
                report($sformatf("left got %0d want %0d",
                                 $signed(l), $signed(want.left)));
            if (r !== want.right)
                report($sformatf("right got %0d want %0d",
                                 $signed(r), $signed(want.right)));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [SB-1:0] i_sample_left;
    logic signed [SB-1:0] i_sample_right;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [SB-1:0] o_out_left;
    logic signed [SB-1:0] o_out_right;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    clip_scoreboard sb;
    bit             steady;
    int             cycles = 0;

    stereo_lookahead_soft_clipper #(
        .SAMPLE_BITS(SB)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall before each transfer, none in the steady phase
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_pair(o_out_left, o_out_right);
        end
    end

    // register write: setup then access, done at the edge with pready high
    task apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task apb_read(logic [2:0] addr, output logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // program the delay spacing and confirm it reads back
    task set_spacing(logic [31:0] value);
        logic [31:0] rd;
        apb_write({REG_SPACING, 2'b00}, value);
        apb_read({REG_SPACING, 2'b00}, rd);
        if (rd[SPACING_W-1:0] !== value[SPACING_W-1:0])
            sb.report($sformatf("spacing read %0d want %0d",
                                rd[SPACING_W-1:0], value[SPACING_W-1:0]));
    endtask

    // one input transfer; valid only drops when a gap is drawn
    task send_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_left  <= l;
        i_sample_right <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pair(l, r);
    endtask

    // block idle: valid dropped at the last transfer edge, nothing due
    task drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // random sample, weighted toward the threshold and the clamp
    function automatic logic signed [SB-1:0] pick_sample();
        longint v;
        int     sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: v = $signed($urandom() & 32'h00FF_FFFF) <<< 8 >>> 8;
            3: v = LIM + $urandom_range(0, 6) - 3;
            4, 5, 6: v = K_T + $urandom_range(0, 8) - 4;
            default: v = longint'($urandom_range(0, 3145728)) - 1572864;
        endcase
        if (sel >= 3 && sel <= 6 && $urandom_range(0, 1)) v = -v;
        return v[SB-1:0];
    endfunction

    longint               edge_vals [$];
    logic [31:0]          space_vals [PHASES];

    initial begin : stimulus
        int n;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_left  = '0;
        i_sample_right = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        steady         = 1'b0;
        sb             = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_spacing(32'd1);

        // directed: threshold edges, both reshape branches, clamp, extremes
        edge_vals = '{0, K_T, K_T + 1, 0, K_T + 1, 8388607, 100,
                      -K_T, -K_T - 1, 0, -K_T - 1, -8388608, 5,
                      -LIM, LIM, LIM + 1, -LIM - 1, 1, -1, K_T + 1, -K_T - 1, 0};
        n = edge_vals.size();
        for (int i = 0; i < n; i++)
            send_pair(SB'(edge_vals[i]), SB'(edge_vals[n - 1 - i]));
        drain();

        // random phases over several spacing values, extremes included
        space_vals[0] = 32'd16;
        space_vals[1] = 32'd0;
        space_vals[2] = 32'd31;
        space_vals[3] = 32'd5;
        space_vals[4] = 32'hFFFF_FFF1;
        space_vals[5] = $urandom_range(1, 16);
        for (int p = 0; p < PHASES; p++) begin
            set_spacing(space_vals[p]);
            steady = (p == 3);
            for (int i = 0; i < PER_PHASE; i++) begin
                // one hold-off until every due result is back
                if (p == 1 && i == PER_PHASE / 2) drain();
                send_pair(pick_sample(), pick_sample());
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
